// File: hw/rtl/blk3_pkg.sv
// ---------------------------------------------------------------------------
// blk3_pkg
// Types, constants and mixing functions shared by the hasher modules.
// ---------------------------------------------------------------------------
package blk3_pkg;

  typedef logic [31:0] word_t;

  // one input beat
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  byte_count;
    logic        last;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic [63:0] digest_bytes;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } out_item_t;

  // configuration register indexes
  localparam logic [2:0]  REG_HASH_MODE      = 3'd0;
  localparam logic [2:0]  REG_KEY_LOW        = 3'd1;
  localparam logic [2:0]  REG_KEY_MID_LOW    = 3'd2;
  localparam logic [2:0]  REG_KEY_MID_HIGH   = 3'd3;
  localparam logic [2:0]  REG_KEY_HIGH       = 3'd4;
  localparam logic [2:0]  REG_OUTPUT_LENGTH  = 3'd5;

  // domain flags
  localparam logic [7:0] FL_START  = 8'h01;
  localparam logic [7:0] FL_END    = 8'h02;
  localparam logic [7:0] FL_PARENT = 8'h04;
  localparam logic [7:0] FL_ROOT   = 8'h08;

  // compression input sources
  localparam logic [1:0] SRC_BLOCK = 2'd0;
  localparam logic [1:0] SRC_MERGE = 2'd1;
  localparam logic [1:0] SRC_NODE  = 2'd2;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [3:0] MSG_PERM [16] = '{
    4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
    4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
  };

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  // controller to datapath
  typedef struct packed {
    logic       latch_in;
    logic       insert;
    logic       comp_start;
    logic [1:0] comp_src;
    logic       comp_root;
    logic       blk_update;
    logic       merge_init;
    logic       merge_step;
    logic       pop;
    logic       push;
    logic       node_init;
    logic       fold_step;
    logic       words_load;
    logic       emit;
    logic       msg_clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_zero;
    logic last_item;
    logic fill_full;
    logic bdone_last;
    logic busy;
    logic tot_odd;
    logic lvl_zero;
    logic out_free;
    logic out_last;
    logic wsel_end;
  } stat_t;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic quad_t g_mix(word_t a, word_t b, word_t c, word_t d,
                                  word_t x, word_t y);
    word_t a1, b1, c1, d1;
    quad_t q;
    a1  = a + b + x;
    d1  = rotr(d ^ a1, 16);
    c1  = c + d1;
    b1  = rotr(b ^ c1, 12);
    q.a = a1 + b1 + y;
    q.d = rotr(d1 ^ q.a, 8);
    q.c = c1 + q.d;
    q.b = rotr(b1 ^ q.c, 7);
    return q;
  endfunction

  function automatic logic [7:0] mode_flag(logic [1:0] mode);
    logic [7:0] f;
    unique case (mode)
      2'd0: f = 8'h00;
      2'd1: f = 8'h10;
      2'd2: f = 8'h20;
      2'd3: f = 8'h40;
    endcase
    return f;
  endfunction

endpackage

// File: hw/rtl/blk3_ram.sv
// ---------------------------------------------------------------------------
// blk3_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module blk3_ram #(
  parameter int WIDTH  = 256,
  parameter int DEPTH  = 54,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/blk3_ctrl.sv
// ---------------------------------------------------------------------------
// blk3_ctrl
// Sequencer: absorb, block and chunk compressions, merges, fold and output.
// ---------------------------------------------------------------------------
module blk3_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  blk3_pkg::stat_t stat,
  output blk3_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ABS    = 4'd1;
  localparam logic [3:0] S_BLK_W  = 4'd2;
  localparam logic [3:0] S_CEND_W = 4'd3;
  localparam logic [3:0] S_MERGE  = 4'd4;
  localparam logic [3:0] S_MRD    = 4'd5;
  localparam logic [3:0] S_MRG_W  = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_FOLD   = 4'd8;
  localparam logic [3:0] S_FOLD_W = 4'd9;
  localparam logic [3:0] S_ROOT   = 4'd10;
  localparam logic [3:0] S_ROOT_W = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;
  localparam logic [3:0] S_CLR    = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_ABS;
        end
      end
      S_ABS: begin
        if (stat.rem_zero) begin
          state_nxt = stat.last_item ? S_FIN : S_IDLE;
        end else if (stat.fill_full) begin
          cmd.comp_start = 1'b1;
          cmd.comp_src   = blk3_pkg::SRC_BLOCK;
          state_nxt      = stat.bdone_last ? S_CEND_W : S_BLK_W;
        end else begin
          cmd.insert = 1'b1;
        end
      end
      S_BLK_W: begin
        if (!stat.busy) begin
          cmd.blk_update = 1'b1;
          state_nxt      = S_ABS;
        end
      end
      S_CEND_W: begin
        if (!stat.busy) begin
          cmd.merge_init = 1'b1;
          state_nxt      = S_MERGE;
        end
      end
      S_MERGE: begin
        if (!stat.tot_odd && !stat.lvl_zero) begin
          cmd.pop   = 1'b1;
          state_nxt = S_MRD;
        end else begin
          cmd.push  = 1'b1;
          state_nxt = S_ABS;
        end
      end
      S_MRD: begin
        cmd.comp_start = 1'b1;
        cmd.comp_src   = blk3_pkg::SRC_MERGE;
        state_nxt      = S_MRG_W;
      end
      S_MRG_W: begin
        if (!stat.busy) begin
          cmd.merge_step = 1'b1;
          state_nxt      = S_MERGE;
        end
      end
      S_FIN: begin
        cmd.node_init = 1'b1;
        state_nxt     = S_FOLD;
      end
      S_FOLD: begin
        if (!stat.lvl_zero) begin
          cmd.comp_start = 1'b1;
          cmd.comp_src   = blk3_pkg::SRC_NODE;
          cmd.pop        = 1'b1;
          state_nxt      = S_FOLD_W;
        end else begin
          state_nxt = S_ROOT;
        end
      end
      S_FOLD_W: begin
        if (!stat.busy) begin
          cmd.fold_step = 1'b1;
          state_nxt     = S_FOLD;
        end
      end
      S_ROOT: begin
        cmd.comp_start = 1'b1;
        cmd.comp_src   = blk3_pkg::SRC_NODE;
        cmd.comp_root  = 1'b1;
        state_nxt      = S_ROOT_W;
      end
      S_ROOT_W: begin
        if (!stat.busy) begin
          cmd.words_load = 1'b1;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.out_last) begin
            state_nxt = S_CLR;
          end else if (stat.wsel_end) begin
            state_nxt = S_ROOT;
          end
        end
      end
      S_CLR: begin
        cmd.msg_clear = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/blk3_dp.sv
// ---------------------------------------------------------------------------
// blk3_dp
// Datapath: config registers, block buffer, chunk state, half-round
// compression unit, chaining-value stack and output word register.
// ---------------------------------------------------------------------------
module blk3_dp #(
  parameter int STACK_DEPTH   = 54,
  parameter int MAX_OUT_BYTES = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_wdata,
  input  blk3_pkg::in_item_t   in_data,
  input  blk3_pkg::cmd_t       cmd,
  output blk3_pkg::stat_t      stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output blk3_pkg::out_item_t  out_data
);

  localparam int         LvlW   = $clog2(STACK_DEPTH + 1);
  localparam int         AddrW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [9:0] MaxOut = 10'(MAX_OUT_BYTES);

  // config registers
  logic [1:0]  mode_r;
  logic [63:0] key_r [4];
  logic [9:0]  olen_r;

  // message state
  logic [255:0]    cv_r;
  logic [511:0]    buf_r;
  logic [6:0]      fill_r;
  logic [3:0]      bdone_r;
  logic [63:0]     cnt_r;
  logic [LvlW-1:0] lvl_r;
  logic [63:0]     dat_r;
  logic [3:0]      rem_r;
  logic            last_r;

  // merge and output node
  logic [255:0] mcv_r;
  logic [63:0]  tot_r;
  logic [255:0] ncv_r;
  logic [511:0] nblk_r;
  logic [63:0]  nctr_r;
  logic [6:0]   nlen_r;
  logic [7:0]   nflg_r;

  // compression unit
  blk3_pkg::word_t v_r [16];
  blk3_pkg::word_t m_r [16];
  blk3_pkg::word_t v_nxt [16];
  blk3_pkg::word_t m_nxt [16];
  logic [255:0]    cvin_r;
  logic [3:0]      step_r;
  logic            busy_r;
  blk3_pkg::quad_t q0, q1, q2, q3;
  logic [511:0]    cout;

  // output side
  logic [511:0]        words_r;
  logic [2:0]          wsel_r;
  logic [2:0]          obk_r;
  logic [9:0]          orem_r;
  logic                out_valid_r;
  blk3_pkg::out_item_t out_data_r;

  // derived values
  logic [255:0] key_w;
  logic [7:0]   mflag;
  logic [6:0]   space, take;
  logic [511:0] buf_ins;
  logic [6:0]   off;
  logic [9:0]   olen_cl;
  logic [63:0]  sel_w, sel_mask;
  logic [3:0]   vcnt;
  logic [255:0] ram_rdata;

  // compression start inputs
  logic [255:0] s_cv;
  logic [511:0] s_blk;
  logic [63:0]  s_ctr;
  logic [6:0]   s_len;
  logic [7:0]   s_flg;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= 64'd0;
      end
      olen_r <= 10'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        blk3_pkg::REG_HASH_MODE:     mode_r   <= cfg_wdata[1:0];
        blk3_pkg::REG_KEY_LOW:       key_r[0] <= cfg_wdata;
        blk3_pkg::REG_KEY_MID_LOW:   key_r[1] <= cfg_wdata;
        blk3_pkg::REG_KEY_MID_HIGH:  key_r[2] <= cfg_wdata;
        blk3_pkg::REG_KEY_HIGH:      key_r[3] <= cfg_wdata;
        blk3_pkg::REG_OUTPUT_LENGTH: olen_r   <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // key of the current mode, mode flag, clamped output length
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key_w[64*i +: 64] = mode_r[0] ? key_r[i]
                                    : {blk3_pkg::IV[2*i+1], blk3_pkg::IV[2*i]};
    end
    mflag = blk3_pkg::mode_flag(mode_r);
    if (olen_r == 10'd0) begin
      olen_cl = 10'd1;
    end else if (olen_r > MaxOut) begin
      olen_cl = MaxOut;
    end else begin
      olen_cl = olen_r;
    end
  end

  // byte insert at the current fill position
  always_comb begin
    space   = 7'd64 - fill_r;
    take    = (7'(rem_r) < space) ? 7'(rem_r) : space;
    buf_ins = buf_r;
    for (int p = 0; p < 64; p++) begin
      off = 7'(p) - fill_r;
      if (7'(p) >= fill_r && 7'(p) < fill_r + take) begin
        buf_ins[8*p +: 8] = dat_r[{off[2:0], 3'b000} +: 8];
      end
    end
  end

  // compression input select
  always_comb begin
    unique case (cmd.comp_src)
      blk3_pkg::SRC_MERGE: begin
        s_cv  = key_w;
        s_blk = {mcv_r, ram_rdata};
        s_ctr = 64'd0;
        s_len = 7'd64;
        s_flg = mflag | blk3_pkg::FL_PARENT;
      end
      blk3_pkg::SRC_NODE: begin
        s_cv  = ncv_r;
        s_blk = nblk_r;
        s_ctr = cmd.comp_root ? {61'd0, obk_r} : nctr_r;
        s_len = nlen_r;
        s_flg = nflg_r | (cmd.comp_root ? blk3_pkg::FL_ROOT : 8'h00);
      end
      default: begin
        s_cv  = (bdone_r == 4'd0) ? key_w : cv_r;
        s_blk = buf_r;
        s_ctr = cnt_r;
        s_len = 7'd64;
        s_flg = mflag | ((bdone_r == 4'd0) ? blk3_pkg::FL_START : 8'h00)
                      | ((bdone_r == 4'd15) ? blk3_pkg::FL_END : 8'h00);
      end
    endcase
  end

  // one half round: columns on even steps, diagonals and permute on odd
  always_comb begin
    v_nxt = v_r;
    m_nxt = m_r;
    if (!step_r[0]) begin
      q0 = blk3_pkg::g_mix(v_r[0], v_r[4], v_r[8],  v_r[12], m_r[0], m_r[1]);
      q1 = blk3_pkg::g_mix(v_r[1], v_r[5], v_r[9],  v_r[13], m_r[2], m_r[3]);
      q2 = blk3_pkg::g_mix(v_r[2], v_r[6], v_r[10], v_r[14], m_r[4], m_r[5]);
      q3 = blk3_pkg::g_mix(v_r[3], v_r[7], v_r[11], v_r[15], m_r[6], m_r[7]);
      {v_nxt[0], v_nxt[4], v_nxt[8],  v_nxt[12]} = q0;
      {v_nxt[1], v_nxt[5], v_nxt[9],  v_nxt[13]} = q1;
      {v_nxt[2], v_nxt[6], v_nxt[10], v_nxt[14]} = q2;
      {v_nxt[3], v_nxt[7], v_nxt[11], v_nxt[15]} = q3;
    end else begin
      q0 = blk3_pkg::g_mix(v_r[0], v_r[5], v_r[10], v_r[15], m_r[8],  m_r[9]);
      q1 = blk3_pkg::g_mix(v_r[1], v_r[6], v_r[11], v_r[12], m_r[10], m_r[11]);
      q2 = blk3_pkg::g_mix(v_r[2], v_r[7], v_r[8],  v_r[13], m_r[12], m_r[13]);
      q3 = blk3_pkg::g_mix(v_r[3], v_r[4], v_r[9],  v_r[14], m_r[14], m_r[15]);
      {v_nxt[0], v_nxt[5], v_nxt[10], v_nxt[15]} = q0;
      {v_nxt[1], v_nxt[6], v_nxt[11], v_nxt[12]} = q1;
      {v_nxt[2], v_nxt[7], v_nxt[8],  v_nxt[13]} = q2;
      {v_nxt[3], v_nxt[4], v_nxt[9],  v_nxt[14]} = q3;
      for (int i = 0; i < 16; i++) begin
        m_nxt[i] = m_r[blk3_pkg::MSG_PERM[i]];
      end
    end
  end

  // compression output words
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cout[32*i +: 32]     = v_r[i] ^ v_r[i+8];
      cout[32*(i+8) +: 32] = v_r[i+8] ^ cvin_r[32*i +: 32];
    end
  end

  // compression unit control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 4'd0;
    end else if (cmd.comp_start) begin
      busy_r <= 1'b1;
      step_r <= 4'd0;
    end else if (busy_r) begin
      step_r <= step_r + 4'd1;
      if (step_r == 4'd13) begin
        busy_r <= 1'b0;
      end
    end
  end

  // compression unit state
  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= s_cv[32*i +: 32];
      end
      for (int i = 0; i < 4; i++) begin
        v_r[8+i] <= blk3_pkg::IV[i];
      end
      v_r[12] <= s_ctr[31:0];
      v_r[13] <= s_ctr[63:32];
      v_r[14] <= 32'(s_len);
      v_r[15] <= 32'(s_flg);
      for (int i = 0; i < 16; i++) begin
        m_r[i] <= s_blk[32*i +: 32];
      end
      cvin_r <= s_cv;
    end else if (busy_r) begin
      v_r <= v_nxt;
      m_r <= m_nxt;
    end
  end

  // message state control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      fill_r  <= 7'd0;
      bdone_r <= 4'd0;
      cnt_r   <= 64'd0;
      lvl_r   <= '0;
      rem_r   <= 4'd0;
      last_r  <= 1'b0;
    end else begin
      if (cmd.latch_in) begin
        rem_r  <= (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;
        last_r <= in_data.last;
      end
      if (cmd.insert) begin
        buf_r  <= buf_ins;
        fill_r <= fill_r + take;
        rem_r  <= rem_r - take[3:0];
      end
      if (cmd.blk_update) begin
        bdone_r <= bdone_r + 4'd1;
        fill_r  <= 7'd0;
        buf_r   <= '0;
      end
      if (cmd.pop) begin
        lvl_r <= lvl_r - LvlW'(1);
      end
      if (cmd.push) begin
        if (lvl_r < LvlW'(STACK_DEPTH)) begin
          lvl_r <= lvl_r + LvlW'(1);
        end
        cnt_r   <= cnt_r + 64'd1;
        buf_r   <= '0;
        fill_r  <= 7'd0;
        bdone_r <= 4'd0;
      end
      if (cmd.msg_clear) begin
        lvl_r   <= '0;
        cnt_r   <= 64'd0;
        buf_r   <= '0;
        fill_r  <= 7'd0;
        bdone_r <= 4'd0;
      end
    end
  end

  // payload registers of absorb, merge and fold
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      dat_r <= in_data.data;
    end else if (cmd.insert) begin
      dat_r <= dat_r >> {take[3:0], 3'b000};
    end
    if (cmd.blk_update) begin
      cv_r <= cout[255:0];
    end
    if (cmd.merge_init) begin
      mcv_r <= cout[255:0];
      tot_r <= cnt_r + 64'd1;
    end else if (cmd.merge_step) begin
      mcv_r <= cout[255:0];
      tot_r <= tot_r >> 1;
    end
    if (cmd.node_init) begin
      ncv_r  <= (bdone_r == 4'd0) ? key_w : cv_r;
      nblk_r <= buf_r;
      nctr_r <= cnt_r;
      nlen_r <= fill_r;
      nflg_r <= mflag | ((bdone_r == 4'd0) ? blk3_pkg::FL_START : 8'h00)
                      | blk3_pkg::FL_END;
    end else if (cmd.fold_step) begin
      ncv_r  <= key_w;
      nblk_r <= {cout[255:0], ram_rdata};
      nctr_r <= 64'd0;
      nlen_r <= 7'd64;
      nflg_r <= mflag | blk3_pkg::FL_PARENT;
    end
    if (cmd.words_load) begin
      words_r <= cout;
    end
  end

  // chaining value stack
  blk3_ram #(
    .WIDTH (256),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.push && (lvl_r < LvlW'(STACK_DEPTH))),
    .wr_addr (AddrW'(lvl_r)),
    .wr_data (mcv_r),
    .rd_en   (cmd.pop),
    .rd_addr (AddrW'(lvl_r - LvlW'(1))),
    .rd_data (ram_rdata)
  );

  // output word select and byte mask
  always_comb begin
    sel_w = words_r[{wsel_r, 6'b000000} +: 64];
    vcnt  = (orem_r > 10'd8) ? 4'd8 : orem_r[3:0];
    for (int b = 0; b < 8; b++) begin
      sel_mask[8*b +: 8] = (4'(b) < vcnt) ? 8'hff : 8'h00;
    end
  end

  // output counters and valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      wsel_r      <= 3'd0;
      obk_r       <= 3'd0;
      orem_r      <= 10'd0;
    end else begin
      if (cmd.node_init) begin
        wsel_r <= 3'd0;
        obk_r  <= 3'd0;
        orem_r <= olen_cl;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        wsel_r      <= wsel_r + 3'd1;
        orem_r      <= (orem_r > 10'd8) ? orem_r - 10'd8 : 10'd0;
        if (wsel_r == 3'd7) begin
          obk_r <= obk_r + 3'd1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.digest_bytes <= sel_w & sel_mask;
      out_data_r.valid_bytes  <= vcnt;
      out_data_r.last_word    <= (orem_r <= 10'd8);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to the sequencer
  always_comb begin
    stat.rem_zero   = (rem_r == 4'd0);
    stat.last_item  = last_r;
    stat.fill_full  = (fill_r == 7'd64);
    stat.bdone_last = (bdone_r == 4'd15);
    stat.busy       = busy_r;
    stat.tot_odd    = tot_r[0];
    stat.lvl_zero   = (lvl_r == '0);
    stat.out_free   = !out_valid_r || out_ready;
    stat.out_last   = (orem_r <= 10'd8);
    stat.wsel_end   = (wsel_r == 3'd7);
  end

endmodule

// File: hw/rtl/blake3_stream_hasher.sv
// ---------------------------------------------------------------------------
// blake3_stream_hasher
// Streaming BLAKE3 hash with keyed, derive-key and extendable output modes.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_ready   blk3_pkg::in_item_t  (8 message bytes)
//   out_     out  out_valid/out_ready blk3_pkg::out_item_t (8 digest bytes)
//   cfg_     in   cfg_we              cfg_index, cfg_wdata (no read-back)
//
// Each full 64-byte block adds one compression of 14 half rounds in the
// shared unit plus handoff. A chunk end adds one push and one parent merge
// per merged stack level, each with one stack RAM read. On last: one
// compression per stack level to fold and one root compression per 64
// output bytes; a beat is issued whenever out_valid is low or out_ready high.
// Synchronous active-low reset; no clearing pass. Input is held off
// whenever the sequencer is not idle, so also while a message is being
// finished; a stalled final output beat does not hold it off.
// ---------------------------------------------------------------------------
module blake3_stream_hasher #(
  parameter int STACK_DEPTH   = 54,
  parameter int MAX_OUT_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  blk3_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output blk3_pkg::out_item_t out_data
);

  blk3_pkg::cmd_t  cmd;
  blk3_pkg::stat_t stat;

  // sequencer
  blk3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  blk3_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .MAX_OUT_BYTES (MAX_OUT_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/blk3_chk.sv
// ---------------------------------------------------------------------------
// blk3_chk
// Port-level checks for the hasher, bound to the top level.
// ---------------------------------------------------------------------------
module blk3_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input blk3_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input blk3_pkg::out_item_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // only the final beat may be short
  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_bytes != 4'd8 |-> out_data.last_word)
    else $error("short digest beat before the last");

  // no input taken in the middle of a digest stream
  a_no_in_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_word |-> !in_ready)
    else $error("input ready during digest output");

  // beat carries at least one byte
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.valid_bytes != 4'd0 && out_data.valid_bytes <= 4'd8)
    else $error("digest byte count out of range");

endmodule

bind blake3_stream_hasher blk3_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
